// ----- hdl/tlpb_pkg.sv -----
// tlpb_pkg: sizes, codes, store request type and priority encode functions
// for the two-level priority bitmap core
// no dependencies
package tlpb_pkg;

    localparam int WORD_BITS   = 32;
    localparam int GROUP_COUNT = 8;
    localparam int INDEX_W     = 8;
    localparam int POS_W       = $clog2(WORD_BITS);
    localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

    localparam logic KIND_SET = 1'b0;
    localparam logic KIND_CLR = 1'b1;

    typedef logic [WORD_BITS-1:0]   t_word;
    typedef logic [GROUP_COUNT-1:0] t_summary;
    typedef logic [GRP_W-1:0]       t_grp;
    typedef logic [POS_W-1:0]       t_pos;

    typedef struct packed {
        logic  rd_en;
        t_grp  rd_addr;
        logic  wr_en;
        t_grp  wr_addr;
        t_word wr_data;
    } t_store_req;

    // highest set bit of a group word, zero when empty
    function automatic t_pos top_pos(input t_word v);
        t_pos n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (v[i]) begin
                n = POS_W'(i);
            end
        end
        return n;
    endfunction

    // highest set bit of the summary word, zero when empty
    function automatic t_grp top_grp(input t_summary v);
        t_grp n;
        n = '0;
        for (int i = 0; i < GROUP_COUNT; i++) begin
            if (v[i]) begin
                n = GRP_W'(i);
            end
        end
        return n;
    endfunction

endpackage

// ----- hdl/two_level_priority_bitmap_core.sv -----
// two_level_priority_bitmap_core: 256-flag ready bitmap, set or clear one
// flag per beat and report the highest flag still set
// o_strobe rises after S_MOD, S_SEL and S_ENC; a new beat is taken only back in S_IDLE, after the steps
// (read group word, write back, read top group word, encode on one port)
// busy is high from acceptance until the result is loaded; o_strobe is
// one cycle wide and the receiver cannot stall
// synchronous active-low reset empties the bitmap (summary and valid bits)
module two_level_priority_bitmap_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [tlpb_pkg::INDEX_W-1:0]  i_bit_index,
    output logic                          o_strobe,
    output logic [tlpb_pkg::INDEX_W-1:0]  o_highest_set,
    output logic                          o_none_set
);

    localparam int WordBits   = tlpb_pkg::WORD_BITS;
    localparam int GroupCount = tlpb_pkg::GROUP_COUNT;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_SEL  = 4'b0100,
        S_ENC  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic                                r_kind;
    tlpb_pkg::t_grp                      r_grp;
    tlpb_pkg::t_pos                      r_pos;
    logic                                r_in_range;
    tlpb_pkg::t_summary                  r_summary, n_summary;
    tlpb_pkg::t_grp                      r_hg;
    logic                                r_strobe;
    logic [tlpb_pkg::INDEX_W-1:0]        r_highest;
    logic                                r_none;

    logic [tlpb_pkg::INDEX_W-1:0]        in_grp_full;
    logic [tlpb_pkg::INDEX_W-1:0]        in_pos_full;
    tlpb_pkg::t_store_req                store_req;
    tlpb_pkg::t_word                     rd_word;
    tlpb_pkg::t_word                     new_word;
    tlpb_pkg::t_word                     bit_sel;
    logic [2*tlpb_pkg::INDEX_W-1:0]      flat_idx;
    logic                                accept;

    assign accept      = start && (r_state == S_IDLE);
    assign in_grp_full = (tlpb_pkg::INDEX_W)'(i_bit_index / WordBits);
    assign in_pos_full = (tlpb_pkg::INDEX_W)'(i_bit_index % WordBits);

    tlpb_word_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_word)
    );

    assign bit_sel = tlpb_pkg::t_word'(1) << r_pos;

    always_comb begin
        unique case (r_kind)
            tlpb_pkg::KIND_SET: new_word = rd_word | bit_sel;
            tlpb_pkg::KIND_CLR: new_word = rd_word & ~bit_sel;
            default:            new_word = rd_word;
        endcase
    end

    always_comb begin
        store_req         = '0;
        store_req.wr_addr = r_grp;
        store_req.wr_data = new_word;
        n_state           = r_state;
        n_summary         = r_summary;
        unique case (r_state)
            S_IDLE: begin
                store_req.rd_en   = accept;
                store_req.rd_addr = in_grp_full[tlpb_pkg::GRP_W-1:0];
                if (accept) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                store_req.wr_en = r_in_range;
                if (r_in_range) begin
                    if (r_kind == tlpb_pkg::KIND_SET) begin
                        n_summary[r_grp] = 1'b1;
                    end else if (new_word == '0) begin
                        n_summary[r_grp] = 1'b0;
                    end
                end
                n_state = S_SEL;
            end
            S_SEL: begin
                // read the word of the top group, after the write back
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = tlpb_pkg::top_grp(r_summary);
                n_state           = S_ENC;
            end
            S_ENC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign flat_idx = (2*tlpb_pkg::INDEX_W)'(r_hg) * (2*tlpb_pkg::INDEX_W)'(WordBits)
                    + (2*tlpb_pkg::INDEX_W)'(tlpb_pkg::top_pos(rd_word));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_summary <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_summary <= n_summary;
            r_strobe  <= (r_state == S_ENC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= i_kind;
            r_grp      <= in_grp_full[tlpb_pkg::GRP_W-1:0];
            r_pos      <= in_pos_full[tlpb_pkg::POS_W-1:0];
            r_in_range <= (32'(in_grp_full) < 32'(GroupCount));
        end
        if (r_state == S_SEL) begin
            r_hg <= tlpb_pkg::top_grp(r_summary);
        end
        if (r_state == S_ENC) begin
            // empty bitmap reports index zero
            r_none    <= (r_summary == '0);
            r_highest <= (r_summary == '0) ? '0 : flat_idx[tlpb_pkg::INDEX_W-1:0];
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_highest_set = r_highest;
    assign o_none_set    = r_none;

endmodule

// ----- hdl/tlpb_word_store.sv -----
// tlpb_word_store: group word memory, one read and one write port,
// registered read data; per-entry valid bits make unwritten entries read zero
// depends on tlpb_pkg
module tlpb_word_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlpb_pkg::t_store_req i_req,
    output tlpb_pkg::t_word     o_rd_data
);

    tlpb_pkg::t_word                    r_mem [tlpb_pkg::GROUP_COUNT];
    logic [tlpb_pkg::GROUP_COUNT-1:0]   r_valid;
    tlpb_pkg::t_word                    r_rd_data;
    logic                               r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_hit <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule
